[hw/rtl/hlle_wave_speed_bounds_macros.svh]
// Assertion macros shared by the HLLE wave speed checker.
`ifndef HLLE_WAVE_SPEED_BOUNDS_MACROS_SVH
`define HLLE_WAVE_SPEED_BOUNDS_MACROS_SVH

// Check a property on the rising edge, ignoring cycles under reset.
`define HWSB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on the rising edge, reset cycles included.
`define HWSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/hwsb_pkg.sv]
// Shared widths and constants of the HLLE wave speed bounds block.
`timescale 1ns / 1ps
`default_nettype none
package hwsb_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NORM_BITS     = 16;
    localparam int DEPTH_W       = 31;
    localparam int MOM_W         = 32;
    localparam int NRM_W         = 18;
    localparam int SPD_W         = 32;
    localparam logic [SPD_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [SPD_W-1:0] S32_MIN = 32'h8000_0000;
endpackage
`default_nettype wire

[hw/rtl/hwsb_in_if.sv]
// Face input channel: valid/ready handshake with the face state payload.
`timescale 1ns / 1ps
`default_nettype none
interface hwsb_in_if import hwsb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [DEPTH_W-1:0]      left_depth;
    logic signed [MOM_W-1:0] left_mom_x;
    logic signed [MOM_W-1:0] left_mom_y;
    logic [DEPTH_W-1:0]      right_depth;
    logic signed [MOM_W-1:0] right_mom_x;
    logic signed [MOM_W-1:0] right_mom_y;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;

    modport source (output valid, left_depth, left_mom_x, left_mom_y, right_depth,
                    right_mom_x, right_mom_y, normal_x, normal_y, input ready);
    modport sink (input valid, left_depth, left_mom_x, left_mom_y, right_depth,
                  right_mom_x, right_mom_y, normal_x, normal_y, output ready);
endinterface
`default_nettype wire

[hw/rtl/hwsb_out_if.sv]
// Wave speed output channel: valid/ready handshake with the speed payload.
`timescale 1ns / 1ps
`default_nettype none
interface hwsb_out_if import hwsb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] min_speed;
    logic signed [SPD_W-1:0] max_speed;
    logic                    depth_error;

    modport source (output valid, min_speed, max_speed, depth_error, input ready);
    modport sink (input valid, min_speed, max_speed, depth_error, output ready);
endinterface
`default_nettype wire

[hw/rtl/hwsb_vel_cell.sv]
// One cell of the velocity chain: a divide step per momentum, a root step per depth.
`timescale 1ns / 1ps
`default_nettype none
module hwsb_vel_cell import hwsb_pkg::*; #(
    parameter int DW     = MOM_W + FRAC_BITS_DEF,
    parameter int SQN    = (DEPTH_W + 1 + FRAC_BITS_DEF) / 2,
    parameter int SIDE_W = 1,
    parameter int IDX    = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [DEPTH_W-1:0]          i_hl,
    input  logic [DEPTH_W-1:0]          i_hr,
    input  logic [3:0][DW-1:0]          i_dq,
    input  logic [3:0][DEPTH_W-1:0]     i_rem,
    input  logic [3:0]                  i_neg,
    input  logic [2:0][2*SQN-1:0]       i_sx,
    input  logic [2:0][SQN:0]           i_srem,
    input  logic [2:0][SQN-1:0]         i_root,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [DEPTH_W-1:0]          o_hl,
    output logic [DEPTH_W-1:0]          o_hr,
    output logic [3:0][DW-1:0]          o_dq,
    output logic [3:0][DEPTH_W-1:0]     o_rem,
    output logic [3:0]                  o_neg,
    output logic [2:0][2*SQN-1:0]       o_sx,
    output logic [2:0][SQN:0]           o_srem,
    output logic [2:0][SQN-1:0]         o_root,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int RW = SQN + 1;

    logic [3:0][DW-1:0]      n_dq;
    logic [3:0][DEPTH_W-1:0] n_rem;
    logic [2:0][2*SQN-1:0]   n_sx;
    logic [2:0][SQN:0]       n_srem;
    logic [2:0][SQN-1:0]     n_root;

    // Restoring divide step: shift one dividend bit in, quotient bit out at the bottom.
    always_comb begin
        logic [DEPTH_W:0] t;
        logic [DEPTH_W:0] dv;
        logic             ge;
        for (int k = 0; k < 4; k++) begin
            dv = (k < 2) ? {1'b0, i_hl} : {1'b0, i_hr};
            t  = {i_rem[k], i_dq[k][DW-1]};
            ge = (t >= dv);
            n_rem[k] = ge ? DEPTH_W'(t - dv) : t[DEPTH_W-1:0];
            n_dq[k]  = {i_dq[k][DW-2:0], ge};
        end
    end

    // Root step: two radicand bits per cell; cells past the root length hold.
    generate
        if (IDX < SQN) begin : g_root
            always_comb begin
                logic [SQN+2:0] st;
                logic [SQN+2:0] tr;
                logic           ge;
                for (int j = 0; j < 3; j++) begin
                    st = {i_srem[j], i_sx[j][2*SQN-1 -: 2]};
                    tr = {1'b0, i_root[j], 2'b01};
                    ge = (st >= tr);
                    n_srem[j] = ge ? RW'(st - tr) : st[SQN:0];
                    n_root[j] = {i_root[j][SQN-2:0], ge};
                    n_sx[j]   = {i_sx[j][2*SQN-3:0], 2'b00};
                end
            end
        end else begin : g_hold
            assign n_srem = i_srem;
            assign n_root = i_root;
            assign n_sx   = i_sx;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hl   <= i_hl;
            o_hr   <= i_hr;
            o_dq   <= n_dq;
            o_rem  <= n_rem;
            o_neg  <= i_neg;
            o_sx   <= n_sx;
            o_srem <= n_srem;
            o_root <= n_root;
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/hwsb_roe_cell.sv]
// One cell of the Roe average chain: a divide step for each velocity component.
`timescale 1ns / 1ps
`default_nettype none
module hwsb_roe_cell import hwsb_pkg::*; #(
    parameter int SQN    = (DEPTH_W + 1 + FRAC_BITS_DEF) / 2,
    parameter int SIDE_W = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [SQN:0]            i_den,
    input  logic [1:0][SQN:0]       i_rem,
    input  logic [1:0][SPD_W-1:0]   i_dq,
    input  logic [1:0]              i_neg,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [SQN:0]            o_den,
    output logic [1:0][SQN:0]       o_rem,
    output logic [1:0][SPD_W-1:0]   o_dq,
    output logic [1:0]              o_neg,
    output logic [SIDE_W-1:0]       o_side
);
    localparam int RW = SQN + 1;

    logic [1:0][SQN:0]     n_rem;
    logic [1:0][SPD_W-1:0] n_dq;

    always_comb begin
        logic [SQN+1:0] t;
        logic [SQN+1:0] dv;
        logic           ge;
        dv = {1'b0, i_den};
        for (int k = 0; k < 2; k++) begin
            t  = {i_rem[k], i_dq[k][SPD_W-1]};
            ge = (t >= dv);
            n_rem[k] = ge ? RW'(t - dv) : t[SQN:0];
            n_dq[k]  = {i_dq[k][SPD_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den  <= i_den;
            o_rem  <= n_rem;
            o_dq   <= n_dq;
            o_neg  <= i_neg;
            o_side <= i_side;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/hlle_wave_speed_bounds.sv]
// HLLE wave speed bounds for 2D shallow water faces, fully pipelined.
//
//  channel   | dir | handshake           | beat payload
//  ----------+-----+---------------------+-------------------------------------------
//  i_face    | in  | valid/ready (sink)  | depths, momenta of both sides, face normal
//  o_speed   | out | valid/ready (source)| min_speed, max_speed, depth_error
//
// One beat enters per cycle while the output is not stalled; the pipeline is made of
// the velocity divide chain (32 + FRAC_BITS cells), the Roe divide chain
// (32 cells) and nine product, sum and saturation stages.
// Reset clears the valid bit of every cell and stage; data registers are not reset.
// A stalled output freezes the whole pipeline in place; i_face.ready follows
// the output register being empty or taken.
`timescale 1ns / 1ps
`default_nettype none
module hlle_wave_speed_bounds import hwsb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hwsb_in_if.sink     i_face,
    hwsb_out_if.source  o_speed
);
    localparam int DW    = MOM_W + FRAC_BITS;             // velocity dividend bits
    localparam int SQN   = (DEPTH_W + 1 + FRAC_BITS) / 2; // root bits
    localparam int XE    = 2 * SQN;                       // padded radicand bits
    localparam int PW    = SQN + SPD_W + 1;               // root times velocity
    localparam int SW    = PW + 1;                        // Roe numerator sum
    localparam int NW    = SQN + SPD_W;                   // Roe numerator magnitude
    localparam int NPW   = SPD_W + NRM_W;                 // velocity times normal
    localparam int PRJ_W = NPW + 1;                       // projection sum
    localparam int CW    = PRJ_W + 1;                     // speed candidates

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic                    err;
    } t_vside;

    typedef struct packed {
        logic signed [SPD_W-1:0] uxl;
        logic signed [SPD_W-1:0] uyl;
        logic signed [SPD_W-1:0] uxr;
        logic signed [SPD_W-1:0] uyr;
        logic [SQN-1:0]          sl;
        logic [SQN-1:0]          sr;
        logic [SQN-1:0]          sm;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic                    err;
    } t_rside;

    // Whole pipeline advances unless the output register holds an untaken beat.
    logic w_adv;
    assign w_adv        = !o_speed.valid || o_speed.ready;
    assign i_face.ready = w_adv;

    // ---------------- velocity and root chain ----------------
    logic                    w_v_vld  [DW+1];
    logic [DEPTH_W-1:0]      w_v_hl   [DW+1];
    logic [DEPTH_W-1:0]      w_v_hr   [DW+1];
    logic [3:0][DW-1:0]      w_v_dq   [DW+1];
    logic [3:0][DEPTH_W-1:0] w_v_rem  [DW+1];
    logic [3:0]              w_v_neg  [DW+1];
    logic [2:0][XE-1:0]      w_v_sx   [DW+1];
    logic [2:0][SQN:0]       w_v_srem [DW+1];
    logic [2:0][SQN-1:0]     w_v_root [DW+1];
    t_vside                  w_v_side [DW+1];

    // Seed the first cell straight from the input beat: momentum magnitudes
    // scaled by 2^FRAC_BITS, radicands of both depths and of the mean depth.
    always_comb begin
        logic signed [MOM_W-1:0] m [4];
        logic [DEPTH_W:0]        hsum;
        m[0] = i_face.left_mom_x;
        m[1] = i_face.left_mom_y;
        m[2] = i_face.right_mom_x;
        m[3] = i_face.right_mom_y;
        for (int k = 0; k < 4; k++) begin
            w_v_neg[0][k] = m[k][MOM_W-1];
            w_v_dq[0][k]  = {(m[k][MOM_W-1] ? (~m[k] + 1'b1) : m[k]), {FRAC_BITS{1'b0}}};
            w_v_rem[0][k] = '0;
        end
        hsum = {1'b0, i_face.left_depth} + {1'b0, i_face.right_depth};
        w_v_sx[0][0] = XE'({i_face.left_depth, {FRAC_BITS{1'b0}}});
        w_v_sx[0][1] = XE'({i_face.right_depth, {FRAC_BITS{1'b0}}});
        w_v_sx[0][2] = XE'({hsum[DEPTH_W:1], {FRAC_BITS{1'b0}}});
        w_v_srem[0]  = '0;
        w_v_root[0]  = '0;
        w_v_hl[0]    = i_face.left_depth;
        w_v_hr[0]    = i_face.right_depth;
        w_v_vld[0]   = i_face.valid;
        w_v_side[0].nx  = i_face.normal_x;
        w_v_side[0].ny  = i_face.normal_y;
        w_v_side[0].err = (i_face.left_depth == '0) || (i_face.right_depth == '0);
    end

    generate
        for (genvar g = 0; g < DW; g++) begin : g_vel
            hwsb_vel_cell #(
                .DW     (DW),
                .SQN    (SQN),
                .SIDE_W ($bits(t_vside)),
                .IDX    (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_adv),
                .i_valid (w_v_vld[g]),
                .i_hl    (w_v_hl[g]),
                .i_hr    (w_v_hr[g]),
                .i_dq    (w_v_dq[g]),
                .i_rem   (w_v_rem[g]),
                .i_neg   (w_v_neg[g]),
                .i_sx    (w_v_sx[g]),
                .i_srem  (w_v_srem[g]),
                .i_root  (w_v_root[g]),
                .i_side  (w_v_side[g]),
                .o_valid (w_v_vld[g+1]),
                .o_hl    (w_v_hl[g+1]),
                .o_hr    (w_v_hr[g+1]),
                .o_dq    (w_v_dq[g+1]),
                .o_rem   (w_v_rem[g+1]),
                .o_neg   (w_v_neg[g+1]),
                .o_sx    (w_v_sx[g+1]),
                .o_srem  (w_v_srem[g+1]),
                .o_root  (w_v_root[g+1]),
                .o_side  (w_v_side[g+1])
            );
        end
    endgenerate

    // Saturate a signed quotient given as magnitude and sign.
    function automatic logic [SPD_W-1:0] f_vsat(input logic [DW-1:0] q, input logic neg);
        logic big;
        if (neg) begin
            big = (q[DW-1:SPD_W] != '0) || (q[SPD_W-1] && (q[SPD_W-2:0] != '0));
            return big ? S32_MIN : (~q[SPD_W-1:0] + 1'b1);
        end
        return (q[DW-1:SPD_W-1] != '0) ? S32_MAX : q[SPD_W-1:0];
    endfunction

    function automatic logic [SPD_W-1:0] f_sat32(input logic [CW-1:0] v);
        if ((v[CW-1:SPD_W-1] == '0) || (v[CW-1:SPD_W-1] == '1)) begin
            return v[SPD_W-1:0];
        end
        return v[CW-1] ? S32_MIN : S32_MAX;
    endfunction

    // ---------------- velocity stage ----------------
    logic                    r_v_vld;
    t_rside                  r_v_side;

    // ---------------- product stage ----------------
    logic                    r_m_vld;
    logic signed [PW-1:0]    r_m_p [4];
    t_rside                  r_m_side;

    // ---------------- numerator sum stage ----------------
    logic                    r_a_vld;
    logic signed [SW-1:0]    r_a_sx;
    logic signed [SW-1:0]    r_a_sy;
    logic [SQN:0]            r_a_den;
    t_rside                  r_a_side;

    // ---------------- magnitude stage, feeds the Roe chain ----------------
    logic                    w_r_vld  [SPD_W+1];
    logic [SQN:0]            w_r_den  [SPD_W+1];
    logic [1:0][SQN:0]       w_r_rem  [SPD_W+1];
    logic [1:0][SPD_W-1:0]   w_r_dq   [SPD_W+1];
    logic [1:0]              w_r_neg  [SPD_W+1];
    t_rside                  w_r_side [SPD_W+1];

    logic                    r_b_vld;
    logic [SQN:0]            r_b_den;
    logic [1:0][SQN:0]       r_b_rem;
    logic [1:0][SPD_W-1:0]   r_b_dq;
    logic [1:0]              r_b_neg;
    t_rside                  r_b_side;

    logic [SW-1:0]           w_mag_x;
    logic [SW-1:0]           w_mag_y;
    assign w_mag_x = r_a_sx[SW-1] ? (~r_a_sx + 1'b1) : r_a_sx;
    assign w_mag_y = r_a_sy[SW-1] ? (~r_a_sy + 1'b1) : r_a_sy;

    assign w_r_vld[0]  = r_b_vld;
    assign w_r_den[0]  = r_b_den;
    assign w_r_rem[0]  = r_b_rem;
    assign w_r_dq[0]   = r_b_dq;
    assign w_r_neg[0]  = r_b_neg;
    assign w_r_side[0] = r_b_side;

    generate
        for (genvar g = 0; g < SPD_W; g++) begin : g_roe
            hwsb_roe_cell #(
                .SQN    (SQN),
                .SIDE_W ($bits(t_rside))
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_adv),
                .i_valid (w_r_vld[g]),
                .i_den   (w_r_den[g]),
                .i_rem   (w_r_rem[g]),
                .i_dq    (w_r_dq[g]),
                .i_neg   (w_r_neg[g]),
                .i_side  (w_r_side[g]),
                .o_valid (w_r_vld[g+1]),
                .o_den   (w_r_den[g+1]),
                .o_rem   (w_r_rem[g+1]),
                .o_dq    (w_r_dq[g+1]),
                .o_neg   (w_r_neg[g+1]),
                .o_side  (w_r_side[g+1])
            );
        end
    endgenerate

    // ---------------- Roe velocity, projection, candidates, output ----------------
    logic                    r_u_vld;
    logic signed [SPD_W-1:0] r_u_ux;
    logic signed [SPD_W-1:0] r_u_uy;
    t_rside                  r_u_side;

    logic                    r_p_vld;
    logic signed [NPW-1:0]   r_p [6];
    logic [SQN-1:0]          r_p_sl;
    logic [SQN-1:0]          r_p_sr;
    logic [SQN-1:0]          r_p_sm;
    logic                    r_p_err;

    logic                    r_s_vld;
    logic signed [PRJ_W-1:0] r_s_unl;
    logic signed [PRJ_W-1:0] r_s_unr;
    logic signed [PRJ_W-1:0] r_s_un;
    logic [SQN-1:0]          r_s_sl;
    logic [SQN-1:0]          r_s_sr;
    logic [SQN-1:0]          r_s_sm;
    logic                    r_s_err;

    logic                    r_c_vld;
    logic signed [CW-1:0]    r_c_alo;
    logic signed [CW-1:0]    r_c_blo;
    logic signed [CW-1:0]    r_c_ahi;
    logic signed [CW-1:0]    r_c_bhi;
    logic                    r_c_err;

    logic                    r_o_vld;
    logic [SPD_W-1:0]        r_o_min;
    logic [SPD_W-1:0]        r_o_max;
    logic                    r_o_err;

    logic signed [PRJ_W-1:0] w_unl;
    logic signed [PRJ_W-1:0] w_unr;
    logic signed [PRJ_W-1:0] w_un;
    assign w_unl = $signed({r_p[0][NPW-1], r_p[0]}) + $signed({r_p[1][NPW-1], r_p[1]});
    assign w_unr = $signed({r_p[2][NPW-1], r_p[2]}) + $signed({r_p[3][NPW-1], r_p[3]});
    assign w_un  = $signed({r_p[4][NPW-1], r_p[4]}) + $signed({r_p[5][NPW-1], r_p[5]});

    logic signed [CW-1:0]    w_ext_sl;
    logic signed [CW-1:0]    w_ext_sr;
    logic signed [CW-1:0]    w_ext_sm;
    assign w_ext_sl = $signed({{(CW-SQN){1'b0}}, r_s_sl});
    assign w_ext_sr = $signed({{(CW-SQN){1'b0}}, r_s_sr});
    assign w_ext_sm = $signed({{(CW-SQN){1'b0}}, r_s_sm});

    logic signed [CW-1:0]    w_lo;
    logic signed [CW-1:0]    w_hi;
    assign w_lo = (r_c_alo < r_c_blo) ? r_c_alo : r_c_blo;
    assign w_hi = (r_c_ahi > r_c_bhi) ? r_c_ahi : r_c_bhi;

    // Valid bits of the stages between and after the chains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_u_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_v_vld <= w_v_vld[DW];
            r_m_vld <= r_v_vld;
            r_a_vld <= r_m_vld;
            r_b_vld <= r_a_vld;
            r_u_vld <= w_r_vld[SPD_W];
            r_p_vld <= r_u_vld;
            r_s_vld <= r_p_vld;
            r_c_vld <= r_s_vld;
            r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // Velocities saturate before anything else touches them.
            r_v_side.uxl <= f_vsat(w_v_dq[DW][0], w_v_neg[DW][0]);
            r_v_side.uyl <= f_vsat(w_v_dq[DW][1], w_v_neg[DW][1]);
            r_v_side.uxr <= f_vsat(w_v_dq[DW][2], w_v_neg[DW][2]);
            r_v_side.uyr <= f_vsat(w_v_dq[DW][3], w_v_neg[DW][3]);
            r_v_side.sl  <= w_v_root[DW][0];
            r_v_side.sr  <= w_v_root[DW][1];
            r_v_side.sm  <= w_v_root[DW][2];
            r_v_side.nx  <= w_v_side[DW].nx;
            r_v_side.ny  <= w_v_side[DW].ny;
            r_v_side.err <= w_v_side[DW].err;

            // Root-weighted velocity products.
            r_m_p[0] <= $signed({1'b0, r_v_side.sl}) * r_v_side.uxl;
            r_m_p[1] <= $signed({1'b0, r_v_side.sr}) * r_v_side.uxr;
            r_m_p[2] <= $signed({1'b0, r_v_side.sl}) * r_v_side.uyl;
            r_m_p[3] <= $signed({1'b0, r_v_side.sr}) * r_v_side.uyr;
            r_m_side <= r_v_side;

            r_a_sx   <= $signed({r_m_p[0][PW-1], r_m_p[0]}) + $signed({r_m_p[1][PW-1], r_m_p[1]});
            r_a_sy   <= $signed({r_m_p[2][PW-1], r_m_p[2]}) + $signed({r_m_p[3][PW-1], r_m_p[3]});
            r_a_den  <= {1'b0, r_m_side.sl} + {1'b0, r_m_side.sr};
            r_a_side <= r_m_side;

            // The quotient fits 32 bits, so the top of the numerator starts
            // below the divisor and only the low word is shifted in.
            r_b_rem[0] <= {1'b0, w_mag_x[NW-1:SPD_W]};
            r_b_rem[1] <= {1'b0, w_mag_y[NW-1:SPD_W]};
            r_b_dq[0]  <= w_mag_x[SPD_W-1:0];
            r_b_dq[1]  <= w_mag_y[SPD_W-1:0];
            r_b_neg    <= {r_a_sy[SW-1], r_a_sx[SW-1]};
            r_b_den    <= r_a_den;
            r_b_side   <= r_a_side;

            r_u_ux   <= w_r_neg[SPD_W][0] ? (~w_r_dq[SPD_W][0] + 1'b1) : w_r_dq[SPD_W][0];
            r_u_uy   <= w_r_neg[SPD_W][1] ? (~w_r_dq[SPD_W][1] + 1'b1) : w_r_dq[SPD_W][1];
            r_u_side <= w_r_side[SPD_W];

            // Project onto the normal.
            r_p[0]  <= r_u_side.uxl * r_u_side.nx;
            r_p[1]  <= r_u_side.uyl * r_u_side.ny;
            r_p[2]  <= r_u_side.uxr * r_u_side.nx;
            r_p[3]  <= r_u_side.uyr * r_u_side.ny;
            r_p[4]  <= r_u_ux * r_u_side.nx;
            r_p[5]  <= r_u_uy * r_u_side.ny;
            r_p_sl  <= r_u_side.sl;
            r_p_sr  <= r_u_side.sr;
            r_p_sm  <= r_u_side.sm;
            r_p_err <= r_u_side.err;

            r_s_unl <= w_unl >>> NORM_BITS;
            r_s_unr <= w_unr >>> NORM_BITS;
            r_s_un  <= w_un >>> NORM_BITS;
            r_s_sl  <= r_p_sl;
            r_s_sr  <= r_p_sr;
            r_s_sm  <= r_p_sm;
            r_s_err <= r_p_err;

            r_c_alo <= $signed({r_s_un[PRJ_W-1], r_s_un}) - w_ext_sm;
            r_c_blo <= $signed({r_s_unl[PRJ_W-1], r_s_unl}) - w_ext_sl;
            r_c_ahi <= $signed({r_s_un[PRJ_W-1], r_s_un}) + w_ext_sm;
            r_c_bhi <= $signed({r_s_unr[PRJ_W-1], r_s_unr}) + w_ext_sr;
            r_c_err <= r_s_err;

            // Zero depth forces both speeds to zero.
            r_o_min <= r_c_err ? '0 : f_sat32(w_lo);
            r_o_max <= r_c_err ? '0 : f_sat32(w_hi);
            r_o_err <= r_c_err;
        end
    end

    assign o_speed.valid       = r_o_vld;
    assign o_speed.min_speed   = r_o_min;
    assign o_speed.max_speed   = r_o_max;
    assign o_speed.depth_error = r_o_err;
endmodule
`default_nettype wire

[hw/rtl/hwsb_checker.sv]
// Port-level checks of the HLLE wave speed block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
`include "hlle_wave_speed_bounds_macros.svh"
module hwsb_checker import hwsb_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [SPD_W-1:0] i_min_speed,
    input logic signed [SPD_W-1:0] i_max_speed,
    input logic                    i_depth_error
);
    // A flagged beat carries zero speeds.
    `HWSB_ASSERT(a_err_zero, i_clk, i_rst_n, i_out_valid && i_depth_error |-> i_min_speed == 0 && i_max_speed == 0, "depth error beat with nonzero speed")
    // The lower bound never exceeds the upper one.
    `HWSB_ASSERT(a_order, i_clk, i_rst_n, i_out_valid && !i_depth_error |-> i_min_speed <= i_max_speed, "min speed above max speed")
    // A stalled output blocks a waiting input beat.
    `HWSB_ASSERT(a_stall, i_clk, i_rst_n, i_out_valid && !i_out_ready && i_in_valid |-> !i_in_ready, "input taken while output stalled")
    `HWSB_ASSERT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_min_speed) && $stable(i_max_speed) && $stable(i_depth_error), "stalled beat changed")
    // Reset empties the output.
    `HWSB_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")
endmodule

bind hlle_wave_speed_bounds hwsb_checker u_hwsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_face.valid),
    .i_in_ready    (i_face.ready),
    .i_out_valid   (o_speed.valid),
    .i_out_ready   (o_speed.ready),
    .i_min_speed   (o_speed.min_speed),
    .i_max_speed   (o_speed.max_speed),
    .i_depth_error (o_speed.depth_error)
);
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the HLLE wave speed bounds block.
`timescale 1ns / 1ps
module tb;
    import hwsb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hwsb_in_if  face_if ();
    hwsb_out_if speed_if ();

    hlle_wave_speed_bounds i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_face  (face_if.sink),
        .o_speed (speed_if.source)
    );

    // 2 ns high, 2 ns low.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int N_RANDOM = 2000;
    localparam int LATENCY  = FRAC + 73;
    localparam int LIMIT    = 400000;

    // Signed 32-bit limits, widened so comparisons are done at 64 bits.
    localparam longint SPD_HI = 64'sd2147483647;
    localparam longint SPD_LO = -64'sd2147483648;

    typedef struct packed {
        logic [DEPTH_W-1:0]      hl;
        logic signed [MOM_W-1:0] mxl;
        logic signed [MOM_W-1:0] myl;
        logic [DEPTH_W-1:0]      hr;
        logic signed [MOM_W-1:0] mxr;
        logic signed [MOM_W-1:0] myr;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
    } t_face;

    typedef struct packed {
        logic signed [SPD_W-1:0] lo;
        logic signed [SPD_W-1:0] hi;
        logic                    err;
    } t_speeds;

    t_speeds pending_speeds[$];
    int      mismatches = 0;
    int      cycles     = 0;

    function automatic longint clamp32(longint v);
        if (v > SPD_HI) return SPD_HI;
        if (v < SPD_LO) return SPD_LO;
        return v;
    endfunction

    // Bitwise integer root of a nonnegative 64-bit value.
    function automatic longint int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint depth_root(longint unsigned d);
        return int_root(d << FRAC);
    endfunction

    // Momentum over depth; SV division truncates toward zero.
    function automatic longint velocity(longint mom, longint d);
        return clamp32((mom <<< FRAC) / d);
    endfunction

    // Arithmetic shift floors negative values.
    function automatic longint normal_vel(longint ux, longint uy, longint nx, longint ny);
        return (ux * nx + uy * ny) >>> NORM_BITS;
    endfunction

    function automatic t_speeds wave_bounds(t_face f);
        t_speeds s;
        longint hl, hr, uxl, uyl, uxr, uyr, sl, sr, den, ux, uy;
        longint unl, unr, un, sm, a, b, lo, hi;
        s = '0;
        if (f.hl == 0 || f.hr == 0) begin
            s.err = 1'b1;
            return s;
        end
        hl  = longint'(f.hl);
        hr  = longint'(f.hr);
        uxl = velocity(longint'(f.mxl), hl);
        uyl = velocity(longint'(f.myl), hl);
        uxr = velocity(longint'(f.mxr), hr);
        uyr = velocity(longint'(f.myr), hr);
        sl  = depth_root(hl);
        sr  = depth_root(hr);
        den = sl + sr;
        ux  = (sl * uxl + sr * uxr) / den;
        uy  = (sl * uyl + sr * uyr) / den;
        unl = normal_vel(uxl, uyl, longint'(f.nx), longint'(f.ny));
        unr = normal_vel(uxr, uyr, longint'(f.nx), longint'(f.ny));
        un  = normal_vel(ux, uy, longint'(f.nx), longint'(f.ny));
        sm  = depth_root((hl + hr) >> 1);
        a = un - sm;
        b = unl - sl;
        lo = (a < b) ? a : b;
        a = un + sm;
        b = unr + sr;
        hi = (a > b) ? a : b;
        s.lo = SPD_W'(clamp32(lo));
        s.hi = SPD_W'(clamp32(hi));
        return s;
    endfunction

    // Directed rows; has_exp marks rows whose result is obvious by inspection.
    typedef struct {
        t_face   f;
        bit      has_exp;
        t_speeds e;
    } t_row;

    t_row rows[$];

    // Field values are given as raw bit patterns and cut to the field widths.
    function automatic t_face mk(longint hl, longint mxl, longint myl,
                                 longint hr, longint mxr, longint myr,
                                 longint nx, longint ny);
        t_face f;
        f.hl = DEPTH_W'(hl); f.mxl = MOM_W'(mxl); f.myl = MOM_W'(myl);
        f.hr = DEPTH_W'(hr); f.mxr = MOM_W'(mxr); f.myr = MOM_W'(myr);
        f.nx = NRM_W'(nx); f.ny = NRM_W'(ny);
        return f;
    endfunction

    task automatic add_row(t_face f, bit has_exp, t_speeds e);
        t_row r;
        r.f = f; r.has_exp = has_exp; r.e = e;
        rows.push_back(r);
    endtask

    function automatic t_face rand_face(bit wellformed);
        t_face f;
        int sel;
        sel = $urandom_range(0, 9);
        if (wellformed) begin
            // Depths around 0.1 .. 100, modest velocities, normal components between -1 and 1.
            f.hl  = DEPTH_W'($urandom_range(6554, 100 << FRAC));
            f.hr  = DEPTH_W'($urandom_range(6554, 100 << FRAC));
            f.mxl = MOM_W'($signed($urandom_range(0, 2 * (200 << FRAC))) - (200 << FRAC));
            f.myl = MOM_W'($signed($urandom_range(0, 2 * (200 << FRAC))) - (200 << FRAC));
            f.mxr = MOM_W'($signed($urandom_range(0, 2 * (200 << FRAC))) - (200 << FRAC));
            f.myr = MOM_W'($signed($urandom_range(0, 2 * (200 << FRAC))) - (200 << FRAC));
            f.nx  = NRM_W'($signed($urandom_range(0, 131072)) - 65536);
            f.ny  = NRM_W'($signed($urandom_range(0, 131072)) - 65536);
        end else begin
            f.hl  = DEPTH_W'($urandom);
            f.hr  = DEPTH_W'($urandom);
            f.mxl = $urandom;
            f.myl = $urandom;
            f.mxr = $urandom;
            f.myr = $urandom;
            f.nx  = NRM_W'($urandom);
            f.ny  = NRM_W'($urandom);
            if (sel == 0) f.hl = '0;
            if (sel == 1) f.hr = '0;
            if (sel == 2) f.hl = DEPTH_W'($urandom_range(1, 16));
            if (sel == 3) f.hr = DEPTH_W'($urandom_range(1, 16));
        end
        return f;
    endfunction

    // Drive one beat at the falling edge and hold until the DUT takes it.
    // Valid stays high after the beat so beats can follow back to back.
    task automatic send_face(t_face f);
        int idle;
        idle = $urandom_range(0, 3);
        if (idle != 0) begin
            face_if.valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        face_if.left_depth  <= f.hl;
        face_if.left_mom_x  <= f.mxl;
        face_if.left_mom_y  <= f.myl;
        face_if.right_depth <= f.hr;
        face_if.right_mom_x <= f.mxr;
        face_if.right_mom_y <= f.myr;
        face_if.normal_x    <= f.nx;
        face_if.normal_y    <= f.ny;
        face_if.valid       <= 1'b1;
        do @(posedge i_clk); while (!face_if.ready);
        pending_speeds.push_back(wave_bounds(f));
        @(negedge i_clk);
    endtask

    // Sink: draw a stall per beat, sample at the rising edge.
    initial begin
        t_speeds want;
        t_speeds got;
        int stall;
        speed_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3);
            @(negedge i_clk);
            if (stall != 0) begin
                speed_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            speed_if.ready <= 1'b1;
            do @(posedge i_clk); while (!speed_if.valid);
            got.lo  = speed_if.min_speed;
            got.hi  = speed_if.max_speed;
            got.err = speed_if.depth_error;
            if (pending_speeds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: lo=%0d hi=%0d err=%0b",
                             got.lo, got.hi, got.err);
            end else begin
                want = pending_speeds.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp lo=%0d hi=%0d err=%0b, got lo=%0d hi=%0d err=%0b",
                                 want.lo, want.hi, want.err, got.lo, got.hi, got.err);
                end
            end
        end
    end

    // Watchdog: count cycles and stop on a hang.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        t_speeds z;
        t_speeds want;
        int tail;
        face_if.valid       = 1'b0;
        face_if.left_depth  = '0;
        face_if.left_mom_x  = '0;
        face_if.left_mom_y  = '0;
        face_if.right_depth = '0;
        face_if.right_mom_x = '0;
        face_if.right_mom_y = '0;
        face_if.normal_x    = '0;
        face_if.normal_y    = '0;

        // Zero depth on either side: error flag, zero speeds.
        z = '0; z.err = 1'b1;
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0), 1, z);
        add_row(mk(0, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 0, 0, 18'h10000, 0), 1, z);
        add_row(mk(31'h7FFFFFFF, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 18'h10000), 1, z);
        // Still water, depth one, normal +x: speeds -1 and +1.
        want = '0; want.lo = SPD_W'(-(1 << FRAC)); want.hi = SPD_W'(1 << FRAC);
        add_row(mk(1 << FRAC, 0, 0, 1 << FRAC, 0, 0, 18'h10000, 0), 1, want);
        // Remaining rows go through the predictor.
        add_row(mk(1 << FRAC, 0, 0, 4 << FRAC, 0, 0, 0, 18'h30000), 0, z);
        add_row(mk(31'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   31'h7FFFFFFF, 32'h80000000, 32'h80000000, 18'h10000, 18'h10000), 0, z);
        // Tiny depth with huge momentum saturates the velocity.
        add_row(mk(1, 32'h7FFFFFFF, 32'h80000000, 1, 32'h80000000, 32'h7FFFFFFF,
                   18'h1FFFF, 18'h20000), 0, z);
        add_row(mk(1, 32'h80000000, 32'h80000000, 1, 32'h80000000, 32'h80000000,
                   18'h10000, 18'h10000), 0, z);
        add_row(mk(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   18'h10000, 18'h10000), 0, z);
        // Out-of-range normal components, used as given.
        add_row(mk(3 << FRAC, 32'hFFFF0000, 5 << FRAC, 2 << FRAC, 7 << FRAC, 32'hFFFE0000,
                   18'h1FFFF, 18'h20001), 0, z);
        add_row(mk(1, 1, 32'hFFFFFFFF, 31'h7FFFFFFF, 32'hFFFFFFFF, 1, 18'h0FFFF, 18'h3FFFF), 0, z);
        add_row(mk(31'h55555555, 32'hAAAAAAAA, 32'h55555555,
                   31'h2AAAAAAA, 32'h55555555, 32'hAAAAAAAA, 18'h15555, 18'h2AAAA), 0, z);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            send_face(rows[k].f);
            if (rows[k].has_exp && wave_bounds(rows[k].f) !== rows[k].e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("predictor disagrees with table row %0d", k);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Hold off once until the pipeline has fully drained.
            if (n == N_RANDOM / 2) begin
                face_if.valid <= 1'b0;
                while (pending_speeds.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            send_face(rand_face($urandom_range(0, 3) != 0));
        end
        face_if.valid <= 1'b0;

        while (pending_speeds.size() != 0) @(posedge i_clk);
        tail = 2 * LATENCY;
        repeat (tail) @(posedge i_clk);

        if (mismatches == 0 && pending_speeds.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

[hlle_wave_speed_bounds.f]
+incdir+hw/rtl
hw/rtl/hwsb_pkg.sv
hw/rtl/hwsb_in_if.sv
hw/rtl/hwsb_out_if.sv
hw/rtl/hwsb_vel_cell.sv
hw/rtl/hwsb_roe_cell.sv
hw/rtl/hlle_wave_speed_bounds.sv
hw/rtl/hwsb_checker.sv
verif/tb.sv
